/* design/sfd_pkg.sv */
// ----------------------------------------------------------------------------
// sfd_pkg
// Types, codes and reset constants shared by the stuffed frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 10;
    localparam int EVENT_W = 2;
    localparam int INDEX_W = 2;
    localparam int CFG_W   = 10;

    // Result queue depth; must be a power of two and at least 4.
    localparam int RESULT_DEPTH = 4;

    // Most results that a single received byte can cause.
    localparam int MAX_RESULTS = 3;

    localparam logic [BYTE_W-1:0] UNSTUFF_FLAG = 8'h02;
    localparam logic [BYTE_W-1:0] UNSTUFF_ESC  = 8'h01;

    localparam logic [EVENT_W-1:0] EV_NONE     = 2'd0;
    localparam logic [EVENT_W-1:0] EV_SHORT    = 2'd1;
    localparam logic [EVENT_W-1:0] EV_OVERFLOW = 2'd2;

    localparam logic [INDEX_W-1:0] REG_FLAG_BYTE     = 2'd0;
    localparam logic [INDEX_W-1:0] REG_ESCAPE_BYTE   = 2'd1;
    localparam logic [INDEX_W-1:0] REG_MIN_FRAME_LEN = 2'd2;
    localparam logic [INDEX_W-1:0] REG_MAX_FRAME_LEN = 2'd3;

    localparam logic [BYTE_W-1:0]  RST_FLAG_BYTE     = 8'h7E;
    localparam logic [BYTE_W-1:0]  RST_ESCAPE_BYTE   = 8'h7D;
    localparam logic [BYTE_W-1:0]  RST_MIN_FRAME_LEN = 8'd6;
    localparam logic [COUNT_W-1:0] RST_MAX_FRAME_LEN = 10'd512;

    typedef struct packed {
        logic [BYTE_W-1:0]  data_byte;
        logic               frame_start;
        logic               frame_end;
        logic [EVENT_W-1:0] event_res;
        logic               last_of_run;
    } result_t;

    typedef struct packed {
        logic               in_frame;
        logic               escape_pending;
        logic [COUNT_W-1:0] stored_count;
    } deframe_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  flag_byte;
        logic [BYTE_W-1:0]  escape_byte;
        logic [BYTE_W-1:0]  min_frame_len;
        logic [COUNT_W-1:0] max_frame_len;
    } deframe_cfg_t;

endpackage

/* design/sfd_if.sv */
// ----------------------------------------------------------------------------
// sfd_if
// Valid/ready channels of the deframer: raw bytes, results and register writes.
// ----------------------------------------------------------------------------
interface sfd_byte_if;
    logic                       valid;
    logic                       ready;
    logic [sfd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_result_if;
    logic                        valid;
    logic                        ready;
    logic [sfd_pkg::BYTE_W-1:0]  data_byte;
    logic                        frame_start;
    logic                        frame_end;
    logic [sfd_pkg::EVENT_W-1:0] event_res;
    logic                        last_of_run;

    modport source (output valid, output data_byte, output frame_start,
                    output frame_end, output event_res, output last_of_run,
                    input ready);
    modport sink   (input valid, input data_byte, input frame_start,
                    input frame_end, input event_res, input last_of_run,
                    output ready);
endinterface

interface sfd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [sfd_pkg::INDEX_W-1:0] index;
    logic [sfd_pkg::CFG_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/stuffed_frame_deframer_core.sv */
// ----------------------------------------------------------------------------
// stuffed_frame_deframer_core
// Byte-stuffed frame receiver: hunts for the opening flag, removes stuffing,
// checks frame length and delivers unstuffed bytes and drop events.
// ----------------------------------------------------------------------------
//  channel   direction  transfer carries
//  rx        in         one raw received byte
//  res       out        one result: byte, start/end marks, event, last mark
//  cfg       in         register index and write data
//
// Each received byte is held in an input register, then handled in a single
// pass, which gives up to three results; they go into a result queue that
// the result channel drains one per cycle while its sink is ready. A byte is
// taken every cycle while results keep pace; the queue's free space for a
// whole run of three is what stalls the input. Reset clears the registers to
// their defaults, returns the deframer to hunting and empties the queue.
module stuffed_frame_deframer_core
#(
    parameter int DEPTH = sfd_pkg::RESULT_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    sfd_byte_if.sink            rx,
    sfd_result_if.source        res,
    sfd_cfg_if.sink             cfg
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - sfd_pkg::MAX_RESULTS);

    sfd_pkg::deframe_cfg_t   cfg_reg;
    sfd_pkg::deframe_state_t state_reg;
    sfd_pkg::deframe_state_t state_next;

    logic                        in_vld_reg;
    logic [sfd_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                        fire;

    logic [1:0]                  step_count;
    sfd_pkg::result_t            step_results [sfd_pkg::MAX_RESULTS];
    logic [1:0]                  push_n;

    sfd_pkg::result_t            queue [DEPTH];
    logic [PTR_W-1:0]            wr_ptr_reg;
    logic [PTR_W-1:0]            rd_ptr_reg;
    logic [CNT_W-1:0]            fill_reg;
    logic                        pop;
    sfd_pkg::result_t            head;

    // Configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_byte     <= sfd_pkg::RST_FLAG_BYTE;
            cfg_reg.escape_byte   <= sfd_pkg::RST_ESCAPE_BYTE;
            cfg_reg.min_frame_len <= sfd_pkg::RST_MIN_FRAME_LEN;
            cfg_reg.max_frame_len <= sfd_pkg::RST_MAX_FRAME_LEN;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                sfd_pkg::REG_FLAG_BYTE:     cfg_reg.flag_byte     <= cfg.data[7:0];
                sfd_pkg::REG_ESCAPE_BYTE:   cfg_reg.escape_byte   <= cfg.data[7:0];
                sfd_pkg::REG_MIN_FRAME_LEN: cfg_reg.min_frame_len <= cfg.data[7:0];
                sfd_pkg::REG_MAX_FRAME_LEN: cfg_reg.max_frame_len <= cfg.data;
            endcase
        end
    end

    // Input register; the held byte is handled once the queue has room for
    // a full run of results.
    assign fire     = in_vld_reg && (fill_reg <= ROOM_LIMIT);
    assign rx.ready = !in_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_vld_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    sfd_step u_step
    (
        .rx_byte      (in_byte_reg),
        .state        (state_reg),
        .cfg          (cfg_reg),
        .state_next   (state_next),
        .result_count (step_count),
        .results      (step_results)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.in_frame       <= 1'b0;
            state_reg.escape_pending <= 1'b0;
            state_reg.stored_count   <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result queue
    assign push_n = fire ? step_count : 2'd0;
    assign head   = queue[rd_ptr_reg];
    assign pop    = res.valid && res.ready;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < sfd_pkg::MAX_RESULTS; k++)
        begin
            if (2'(k) < push_n)
            begin
                queue[wr_ptr_reg + PTR_W'(k)] <= step_results[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            fill_reg <= fill_reg + CNT_W'(push_n) - CNT_W'(pop);
        end
    end

    assign res.valid       = (fill_reg != '0);
    assign res.data_byte   = head.data_byte;
    assign res.frame_start = head.frame_start;
    assign res.frame_end   = head.frame_end;
    assign res.event_res   = head.event_res;
    assign res.last_of_run = head.last_of_run;

endmodule

/* design/sfd_step.sv */
// ----------------------------------------------------------------------------
// sfd_step
// Handles one received byte: hunting, unstuffing, length checks and the
// results that the byte causes, together with the next deframer state.
// ----------------------------------------------------------------------------
module sfd_step
(
    input  logic [sfd_pkg::BYTE_W-1:0] rx_byte,
    input  sfd_pkg::deframe_state_t    state,
    input  sfd_pkg::deframe_cfg_t      cfg,
    output sfd_pkg::deframe_state_t    state_next,
    output logic [1:0]                 result_count,
    output sfd_pkg::result_t           results [sfd_pkg::MAX_RESULTS]
);

    function automatic sfd_pkg::result_t make_result(
        input logic [sfd_pkg::BYTE_W-1:0]  data,
        input logic                        start,
        input logic                        stop,
        input logic [sfd_pkg::EVENT_W-1:0] ev
    );
        sfd_pkg::result_t r;
        r.data_byte   = data;
        r.frame_start = start;
        r.frame_end   = stop;
        r.event_res   = ev;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    logic                                   in_frame;
    logic                                   esc_pend;
    logic [sfd_pkg::COUNT_W-1:0]            count;
    logic [1:0]                             n;
    sfd_pkg::result_t                       res [sfd_pkg::MAX_RESULTS];
    logic                                   is_flag;
    logic                                   is_escape;

    always_comb
    begin
        in_frame  = state.in_frame;
        esc_pend  = state.escape_pending;
        count     = state.stored_count;
        n         = 2'd0;
        is_flag   = (rx_byte == cfg.flag_byte);
        is_escape = (rx_byte == cfg.escape_byte);
        for (int k = 0; k < sfd_pkg::MAX_RESULTS; k++)
        begin
            res[k] = make_result('0, 1'b0, 1'b0, sfd_pkg::EV_NONE);
        end

        // A full frame is dropped before the new byte is looked at.
        if (in_frame && ({1'b0, count} + 11'd1 > {1'b0, cfg.max_frame_len}))
        begin
            if (esc_pend)
            begin
                res[n] = make_result(cfg.escape_byte, 1'b0, 1'b0, sfd_pkg::EV_NONE);
                n      = n + 2'd1;
            end
            res[n]   = make_result('0, 1'b0, 1'b0, sfd_pkg::EV_OVERFLOW);
            n        = n + 2'd1;
            in_frame = 1'b0;
            esc_pend = 1'b0;
            count    = '0;
        end

        if (!in_frame)
        begin
            if (is_flag)
            begin
                res[n]   = make_result(cfg.flag_byte, 1'b1, 1'b0, sfd_pkg::EV_NONE);
                n        = n + 2'd1;
                in_frame = 1'b1;
                esc_pend = 1'b0;
                count    = sfd_pkg::COUNT_W'(1);
            end
        end
        else if (is_flag)
        begin
            if (esc_pend)
            begin
                res[n] = make_result(cfg.escape_byte, 1'b0, 1'b0, sfd_pkg::EV_NONE);
                n      = n + 2'd1;
            end
            esc_pend = 1'b0;
            if (count < {2'b00, cfg.min_frame_len})
            begin
                // Too short to close: drop it and let this flag open a new frame.
                res[n] = make_result('0, 1'b0, 1'b0, sfd_pkg::EV_SHORT);
                n      = n + 2'd1;
                res[n] = make_result(cfg.flag_byte, 1'b1, 1'b0, sfd_pkg::EV_NONE);
                n      = n + 2'd1;
                count  = sfd_pkg::COUNT_W'(1);
            end
            else
            begin
                res[n]   = make_result(cfg.flag_byte, 1'b0, 1'b1, sfd_pkg::EV_NONE);
                n        = n + 2'd1;
                in_frame = 1'b0;
                count    = '0;
            end
        end
        else if (is_escape && !esc_pend)
        begin
            // The escape is counted now and resolved with the byte after it.
            esc_pend = 1'b1;
            count    = count + sfd_pkg::COUNT_W'(1);
        end
        else if (esc_pend && rx_byte == sfd_pkg::UNSTUFF_FLAG)
        begin
            res[n]   = make_result(cfg.flag_byte, 1'b0, 1'b0, sfd_pkg::EV_NONE);
            n        = n + 2'd1;
            esc_pend = 1'b0;
        end
        else if (esc_pend && rx_byte == sfd_pkg::UNSTUFF_ESC)
        begin
            res[n]   = make_result(cfg.escape_byte, 1'b0, 1'b0, sfd_pkg::EV_NONE);
            n        = n + 2'd1;
            esc_pend = 1'b0;
        end
        else
        begin
            if (esc_pend)
            begin
                res[n] = make_result(cfg.escape_byte, 1'b0, 1'b0, sfd_pkg::EV_NONE);
                n      = n + 2'd1;
            end
            res[n]   = make_result(rx_byte, 1'b0, 1'b0, sfd_pkg::EV_NONE);
            n        = n + 2'd1;
            esc_pend = 1'b0;
            count    = count + sfd_pkg::COUNT_W'(1);
        end

        for (int k = 0; k < sfd_pkg::MAX_RESULTS; k++)
        begin
            res[k].last_of_run = (2'(k) + 2'd1 == n);
        end
    end

    assign state_next.in_frame       = in_frame;
    assign state_next.escape_pending = esc_pend;
    assign state_next.stored_count   = count;
    assign result_count              = n;
    assign results                   = res;

endmodule
